// ----- rtl/agm_pkg.sv -----
// Shared types and constants for the Adam gradient step block.
`default_nettype none
package agm_pkg;

  localparam int unsigned LAYER_W = 3;
  localparam int unsigned ELEM_W  = 10;
  localparam int unsigned GRAD_W  = 32;
  localparam int unsigned M_W     = 32;
  localparam int unsigned V_W     = 48;
  localparam int unsigned P_W     = 32;
  localparam int unsigned C_W     = 33;
  localparam int unsigned BETA_W  = 16;
  localparam int unsigned ROOT_W  = 32;
  localparam int unsigned MHAT_W  = 64;
  localparam int unsigned DATA_W  = 48;
  localparam int unsigned REG_W   = 2;

  localparam logic [REG_W-1:0] REG_BETA_FIRST   = 2'd0;
  localparam logic [REG_W-1:0] REG_BETA_SECOND  = 2'd1;
  localparam logic [REG_W-1:0] REG_EPSILON_TERM = 2'd2;

  localparam logic [BETA_W-1:0] BETA_FIRST_RST   = 16'd58982;
  localparam logic [BETA_W-1:0] BETA_SECOND_RST  = 16'd65470;
  localparam logic [BETA_W-1:0] EPSILON_TERM_RST = 16'd1;
  localparam logic [P_W-1:0]    POWER_ONE        = 32'hFFFF_FFFF;

  typedef struct packed {
    logic                     valid;
    logic [LAYER_W-1:0]       layer;
    logic [ELEM_W-1:0]        elem;
    logic                     inrange;
    logic signed [M_W-1:0]    m;
    logic [V_W-1:0]           v;
    logic [C_W-1:0]           c1;
    logic [C_W-1:0]           c2;
  } mom_t;

  typedef struct packed {
    logic [LAYER_W-1:0] layer;
    logic [ELEM_W-1:0]  elem;
    logic               inrange;
    logic               neg;
    logic [V_W-1:0]     v;
    logic [C_W-1:0]     c2;
  } mdiv_side_t;

  typedef struct packed {
    logic [LAYER_W-1:0] layer;
    logic [ELEM_W-1:0]  elem;
    logic               inrange;
    logic               neg;
    logic [MHAT_W-1:0]  mhat;
    logic               vsat;
  } vdiv_side_t;

  typedef struct packed {
    logic [LAYER_W-1:0] layer;
    logic [ELEM_W-1:0]  elem;
    logic               inrange;
    logic               neg;
    logic [MHAT_W-1:0]  mhat;
  } sqrt_side_t;

  typedef struct packed {
    logic [LAYER_W-1:0] layer;
    logic [ELEM_W-1:0]  elem;
    logic               inrange;
    logic               neg;
    logic               zero;
    logic               sat;
  } qdiv_side_t;

endpackage
`default_nettype wire

// ----- rtl/adam_gradient_step.sv -----
// Adam gradient step: moment update, bias correction and normalization of a gradient stream.
// Pipeline: 2 moment stages, 64 + 48 quotient-bit stages, 32 root stages, 33 quotient-bit stages,
//   output buffer.
// Throughput: one item per cycle while no clearing pass runs and the output buffer is not full;
//   the moment read-modify-write forwards back-to-back hits. Reset: both moment memories are cleared
//   one entry per cycle, all NUM_LAYERS*WEIGHTS_PER_LAYER entries (8192 by default); no item is taken meanwhile.
`default_nettype none
module adam_gradient_step import agm_pkg::*; #(
  parameter int unsigned NUM_LAYERS        = 8,
  parameter int unsigned WEIGHTS_PER_LAYER = 1024
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [DATA_W-1:0] s_axis_tdata,  // layer_index, element_index, raw_gradient
  input  wire logic [0:0]        s_axis_tuser,  // new_sample
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [DATA_W-1:0]      m_axis_tdata,  // layer_echo, element_echo, adjusted_gradient
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [REG_W-1:0]  cfg_index_i,
  input  wire logic [BETA_W-1:0] cfg_data_i
);

  logic [BETA_W-1:0] beta1_q, beta2_q, eps_q;
  logic              busy, full, en, acc;
  mom_t              mom;

  mdiv_side_t        md_in, md_out;
  vdiv_side_t        vd_in, vd_out;
  sqrt_side_t        sq_in, sq_out;
  qdiv_side_t        qd_in, qd_out;
  logic              md_valid, vd_valid, sq_valid, qd_valid;
  logic [MHAT_W-1:0] mhat;
  logic [V_W-1:0]    vquo, vhat;
  logic [ROOT_W-1:0] root;
  logic [C_W-1:0]    denom, qquo, qv, qc;
  logic [M_W-1:0]    mmag;
  logic [GRAD_W-1:0] res;

  assign cfg_ready_o   = 1'b1;
  assign en            = !busy && !full;
  assign s_axis_tready = en;
  assign acc           = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta1_q <= BETA_FIRST_RST;
      beta2_q <= BETA_SECOND_RST;
      eps_q   <= EPSILON_TERM_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_BETA_FIRST:   beta1_q <= cfg_data_i;
        REG_BETA_SECOND:  beta2_q <= cfg_data_i;
        REG_EPSILON_TERM: eps_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  agm_moment #(
    .NUM_LAYERS        (NUM_LAYERS),
    .WEIGHTS_PER_LAYER (WEIGHTS_PER_LAYER)
  ) u_moment (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (acc),
    .layer_i      (s_axis_tdata[2:0]),
    .elem_i       (s_axis_tdata[12:3]),
    .grad_i       (s_axis_tdata[44:13]),
    .new_sample_i (s_axis_tuser[0]),
    .beta1_i      (beta1_q),
    .beta2_i      (beta2_q),
    .busy_o       (busy),
    .mom_o        (mom)
  );

  always_comb begin
    mmag        = mom.m[M_W-1] ? (~mom.m + 32'd1) : mom.m;
    md_in.layer   = mom.layer;
    md_in.elem    = mom.elem;
    md_in.inrange = mom.inrange;
    md_in.neg     = mom.m[M_W-1];
    md_in.v       = mom.v;
    md_in.c2      = mom.c2;
  end

  agm_div #(.DW(C_W), .QB(MHAT_W), .SW($bits(mdiv_side_t))) u_mdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (mom.valid),
    .rem_i   ('0),
    .div_i   (mom.c1),
    .num_i   ({mmag, 32'd0}),
    .side_i  (md_in),
    .valid_o (md_valid),
    .quo_o   (mhat),
    .side_o  (md_out)
  );

  always_comb begin
    vd_in.layer   = md_out.layer;
    vd_in.elem    = md_out.elem;
    vd_in.inrange = md_out.inrange;
    vd_in.neg     = md_out.neg;
    vd_in.mhat    = mhat;
    vd_in.vsat    = ({1'b0, md_out.v[47:16]} >= md_out.c2);
  end

  agm_div #(.DW(C_W), .QB(V_W), .SW($bits(vdiv_side_t))) u_vdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (md_valid),
    .rem_i   ({1'b0, md_out.v[47:16]}),
    .div_i   (md_out.c2),
    .num_i   ({md_out.v[15:0], 32'd0}),
    .side_i  (vd_in),
    .valid_o (vd_valid),
    .quo_o   (vquo),
    .side_o  (vd_out)
  );

  always_comb begin
    vhat          = vd_out.vsat ? '1 : vquo;
    sq_in.layer   = vd_out.layer;
    sq_in.elem    = vd_out.elem;
    sq_in.inrange = vd_out.inrange;
    sq_in.neg     = vd_out.neg;
    sq_in.mhat    = vd_out.mhat;
  end

  agm_sqrt #(.IW(64), .SW($bits(sqrt_side_t))) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vd_valid),
    .x_i     ({vhat, 16'd0}),
    .side_i  (sq_in),
    .valid_o (sq_valid),
    .root_o  (root),
    .side_o  (sq_out)
  );

  always_comb begin
    denom         = {1'b0, root} + {17'd0, eps_q};
    qd_in.layer   = sq_out.layer;
    qd_in.elem    = sq_out.elem;
    qd_in.inrange = sq_out.inrange;
    qd_in.neg     = sq_out.neg;
    qd_in.zero    = (sq_out.mhat == '0);
    qd_in.sat     = (sq_out.mhat[63:17] >= {14'd0, denom});
  end

  agm_div #(.DW(C_W), .QB(C_W), .SW($bits(qdiv_side_t))) u_qdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .rem_i   (sq_out.mhat[49:17]),
    .div_i   (denom),
    .num_i   ({sq_out.mhat[16:0], 16'd0}),
    .side_i  (qd_in),
    .valid_o (qd_valid),
    .quo_o   (qquo),
    .side_o  (qd_out)
  );

  always_comb begin
    qv = qd_out.sat ? '1 : qquo;
    if (qd_out.neg) begin
      qc  = (qv > 33'h0_8000_0000) ? 33'h0_8000_0000 : qv;
      res = ~qc[31:0] + 32'd1;
    end else begin
      qc  = (qv > 33'h0_7FFF_FFFF) ? 33'h0_7FFF_FFFF : qv;
      res = qc[31:0];
    end
    if (!qd_out.inrange || qd_out.zero) begin
      res = '0;
    end
  end

  agm_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (qd_valid && en),
    .data_i  ({3'd0, res, qd_out.elem, qd_out.layer}),
    .full_o  (full),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (m_axis_tdata)
  );

  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !s_axis_tready)
    else $error("item accepted during clearing pass");

  a_clear_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !m_axis_tvalid)
    else $error("result present during clearing pass");

  a_full_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> m_axis_tvalid)
    else $error("output buffer full without a visible result");

endmodule
`default_nettype wire

// ----- rtl/agm_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`default_nettype none
module agm_div #(
  parameter int unsigned DW = 33,
  parameter int unsigned QB = 64,
  parameter int unsigned SW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic [DW-1:0] rem_i,
  input  wire logic [DW-1:0] div_i,
  input  wire logic [QB-1:0] num_i,
  input  wire logic [SW-1:0] side_i,
  output logic               valid_o,
  output logic [QB-1:0]      quo_o,
  output logic [SW-1:0]      side_o
);

  logic          vld  [QB+1];
  logic [DW-1:0] rem  [QB+1];
  logic [DW-1:0] dvs  [QB+1];
  logic [QB-1:0] num  [QB+1];
  logic [SW-1:0] side [QB+1];

  assign vld[0]  = valid_i;
  assign rem[0]  = rem_i;
  assign dvs[0]  = div_i;
  assign num[0]  = num_i;
  assign side[0] = side_i;

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [DW:0] t;
    logic [DW:0] diff;
    logic        ge;
    always_comb begin
      t    = {rem[k], num[k][QB-1]};
      diff = t - {1'b0, dvs[k]};
      ge   = (t >= {1'b0, dvs[k]});
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[k+1] <= 1'b0;
      end else if (en_i) begin
        vld[k+1] <= vld[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem[k+1]  <= ge ? diff[DW-1:0] : t[DW-1:0];
        dvs[k+1]  <= dvs[k];
        num[k+1]  <= {num[k][QB-2:0], ge};
        side[k+1] <= side[k];
      end
    end
  end

  assign valid_o = vld[QB];
  assign quo_o   = num[QB];
  assign side_o  = side[QB];

endmodule
`default_nettype wire

// ----- rtl/agm_sqrt.sv -----
// Pipelined integer square root, one root bit per stage, with sideband.
`default_nettype none
module agm_sqrt #(
  parameter int unsigned IW = 64,
  parameter int unsigned SW = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire logic [IW-1:0]   x_i,
  input  wire logic [SW-1:0]   side_i,
  output logic                 valid_o,
  output logic [IW/2-1:0]      root_o,
  output logic [SW-1:0]        side_o
);

  localparam int unsigned RW = IW / 2;

  logic          vld  [RW+1];
  logic [RW+1:0] rem  [RW+1];
  logic [RW-1:0] root [RW+1];
  logic [IW-1:0] xs   [RW+1];
  logic [SW-1:0] side [RW+1];

  assign vld[0]  = valid_i;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign xs[0]   = x_i;
  assign side[0] = side_i;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW+3:0] t;
    logic [RW+3:0] trial;
    logic [RW+3:0] diff;
    logic          ge;
    always_comb begin
      t     = {rem[k], xs[k][IW-1:IW-2]};
      trial = {2'b00, root[k], 2'b01};
      diff  = t - trial;
      ge    = (t >= trial);
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[k+1] <= 1'b0;
      end else if (en_i) begin
        vld[k+1] <= vld[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem[k+1]  <= ge ? diff[RW+1:0] : t[RW+1:0];
        root[k+1] <= {root[k][RW-2:0], ge};
        xs[k+1]   <= {xs[k][IW-3:0], 2'b00};
        side[k+1] <= side[k];
      end
    end
  end

  assign valid_o = vld[RW];
  assign root_o  = root[RW];
  assign side_o  = side[RW];

endmodule
`default_nettype wire

// ----- rtl/agm_moment.sv -----
// Moment stores with read-modify-write, forwarding, clearing pass and step powers.
`default_nettype none
module agm_moment import agm_pkg::*; #(
  parameter int unsigned NUM_LAYERS        = 8,
  parameter int unsigned WEIGHTS_PER_LAYER = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     en_i,
  input  wire logic                     valid_i,
  input  wire logic [LAYER_W-1:0]       layer_i,
  input  wire logic [ELEM_W-1:0]        elem_i,
  input  wire logic signed [GRAD_W-1:0] grad_i,
  input  wire logic                     new_sample_i,
  input  wire logic [BETA_W-1:0]        beta1_i,
  input  wire logic [BETA_W-1:0]        beta2_i,
  output logic                          busy_o,
  output mom_t                          mom_o
);

  localparam int unsigned DEPTH = NUM_LAYERS * WEIGHTS_PER_LAYER;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  typedef struct packed {
    logic                     valid;
    logic [LAYER_W-1:0]       layer;
    logic [ELEM_W-1:0]        elem;
    logic                     inrange;
    logic [AW-1:0]            idx;
    logic signed [GRAD_W-1:0] g;
    logic [V_W-1:0]           sq;
    logic [C_W-1:0]           c1;
    logic [C_W-1:0]           c2;
    logic                     fwd;
  } stage_t;

  logic signed [M_W-1:0] mmem [DEPTH];
  logic [V_W-1:0]        vmem [DEPTH];

  logic                  clr_q;
  logic [AW-1:0]         clr_addr_q;
  logic [P_W-1:0]        p1_q, p1_d, p2_q, p2_d;
  stage_t                s1_q, s1_d;
  mom_t                  mom_q, mom_d;
  logic signed [M_W-1:0] m_rd_q, fwd_m_q;
  logic [V_W-1:0]        v_rd_q, fwd_v_q;

  logic                  inrange;
  logic [AW-1:0]         idx;
  logic [47:0]           prod1, prod2;
  logic [GRAD_W-1:0]     gmag;
  logic [63:0]           gsq;
  logic signed [M_W-1:0] m_old, m_new;
  logic [V_W-1:0]        v_old, v_new;
  logic [16:0]           omb1, omb2;
  logic signed [50:0]    accm;
  logic signed [34:0]    msh;
  logic [65:0]           accv;
  logic [49:0]           vsh;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;

  always_comb begin
    inrange = (32'(layer_i) < NUM_LAYERS) && (32'(elem_i) < WEIGHTS_PER_LAYER);
    idx     = AW'(32'(layer_i) * WEIGHTS_PER_LAYER + 32'(elem_i));
    prod1   = p1_q * beta1_i + 48'd32768;
    prod2   = p2_q * beta2_i + 48'd32768;
    p1_d    = (valid_i && new_sample_i) ? prod1[47:16] : p1_q;
    p2_d    = (valid_i && new_sample_i) ? prod2[47:16] : p2_q;
    gmag    = grad_i[GRAD_W-1] ? (~grad_i + 32'd1) : grad_i;
    gsq     = gmag * gmag;

    s1_d.valid   = valid_i;
    s1_d.layer   = layer_i;
    s1_d.elem    = elem_i;
    s1_d.inrange = inrange;
    s1_d.idx     = idx;
    s1_d.g       = grad_i;
    s1_d.sq      = gsq[63:16];
    s1_d.c1      = 33'h1_0000_0000 - {1'b0, p1_d};
    s1_d.c2      = 33'h1_0000_0000 - {1'b0, p2_d};
    s1_d.fwd     = s1_q.valid && s1_q.inrange && inrange && (s1_q.idx == idx);
  end

  always_comb begin
    m_old = s1_q.fwd ? fwd_m_q : m_rd_q;
    v_old = s1_q.fwd ? fwd_v_q : v_rd_q;
    omb1  = 17'd65536 - {1'b0, beta1_i};
    omb2  = 17'd65536 - {1'b0, beta2_i};
    accm  = $signed({1'b0, beta1_i}) * m_old + $signed({1'b0, omb1}) * s1_q.g + 51'sd32768;
    msh   = accm[50:16];
    if (msh > 35'sd2147483647) begin
      m_new = 32'sh7FFF_FFFF;
    end else if (msh < -35'sd2147483648) begin
      m_new = 32'sh8000_0000;
    end else begin
      m_new = msh[31:0];
    end
    accv  = beta2_i * v_old + omb2 * s1_q.sq + 66'd32768;
    vsh   = accv[65:16];
    v_new = (|vsh[49:48]) ? '1 : vsh[47:0];

    mom_d.valid   = s1_q.valid;
    mom_d.layer   = s1_q.layer;
    mom_d.elem    = s1_q.elem;
    mom_d.inrange = s1_q.inrange;
    mom_d.m       = m_new;
    mom_d.v       = v_new;
    mom_d.c1      = s1_q.c1;
    mom_d.c2      = s1_q.c2;

    wr_en   = clr_q || (en_i && s1_q.valid && s1_q.inrange);
    wr_addr = clr_q ? clr_addr_q : s1_q.idx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      p1_q       <= POWER_ONE;
      p2_q       <= POWER_ONE;
      s1_q       <= '0;
      mom_q      <= '0;
    end else begin
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + AW'(1);
        if (clr_addr_q == LAST_ADDR) begin
          clr_q <= 1'b0;
        end
      end
      if (en_i) begin
        p1_q  <= p1_d;
        p2_q  <= p2_d;
        s1_q  <= s1_d;
        mom_q <= mom_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fwd_m_q <= m_new;
      fwd_v_q <= v_new;
      m_rd_q  <= mmem[idx];
      v_rd_q  <= vmem[idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mmem[wr_addr] <= clr_q ? '0 : m_new;
      vmem[wr_addr] <= clr_q ? '0 : v_new;
    end
  end

  assign busy_o = clr_q;
  assign mom_o  = mom_q;

endmodule
`default_nettype wire

// ----- rtl/agm_outbuf.sv -----
// Two-entry output buffer between the pipeline and the result stream.
`default_nettype none
module agm_outbuf import agm_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [DATA_W-1:0] data_i,
  output logic                   full_o,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output logic [DATA_W-1:0]      data_o
);

  logic [1:0]        cnt_q, cnt_d;
  logic [DATA_W-1:0] slot0_q, slot1_q;
  logic              pop;

  assign pop = valid_o && ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      slot0_q <= (cnt_q == 2'd2) ? slot1_q : data_i;
      if (push_i && cnt_q == 2'd2) begin
        slot1_q <= data_i;
      end
    end else if (push_i) begin
      if (cnt_q == 2'd0) begin
        slot0_q <= data_i;
      end else begin
        slot1_q <= data_i;
      end
    end
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = slot0_q;

endmodule
`default_nettype wire
